// File: hw/rtl/fspq_pkg.sv
// Package for the four-level stable priority queue.
// Holds field widths, request and status codes, the controller command and
// datapath status structs, and the level-to-class mapping. No dependencies.
package fspq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    localparam int ENTRY_ID_W = 16;
    localparam int LEVEL_W    = 3;
    localparam int CODE_W     = 2;
    localparam int CLASS_W    = 2;
    localparam int STATUS_W   = 3;

    // Request kinds.
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_POP     = 2'd1;
    localparam logic [1:0] KIND_POP_ALL = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_SERVED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd4;

    // Table classes.
    localparam logic [CLASS_W-1:0] CLASS_VVIP    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_VIP     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_REGULAR = 2'd2;

    // Stored level codes (level minus one).
    localparam logic [CODE_W-1:0] CODE_LEVEL3 = 2'd2;
    localparam logic [CODE_W-1:0] CODE_LEVEL4 = 2'd3;

    // Command from the controller to the datapath for one cycle.
    typedef struct packed {
        logic                push;
        logic                pop;
        logic                clear;
        logic                emit;
        logic                serve;
        logic                last;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // Queue status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic one_left;
        logic full;
    } dp_status_t;

    function automatic logic [CLASS_W-1:0] class_of(input logic [CODE_W-1:0] code);
        logic [CLASS_W-1:0] cls;
        if (code == CODE_LEVEL4)
            cls = CLASS_VVIP;
        else if (code == CODE_LEVEL3)
            cls = CLASS_VIP;
        else
            cls = CLASS_REGULAR;
        return cls;
    endfunction

endpackage

// File: hw/rtl/fspq_ctrl.sv
// Controller state machine of the four-level stable priority queue.
// Decodes requests and sequences the drain of a pop-all; depends on fspq_pkg.
module fspq_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               kind,
    input  fspq_pkg::dp_status_t     dp_status,
    output fspq_pkg::cmd_t           cmd,
    output logic                     busy
);

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg == ST_DRAIN);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    unique case (kind)
                        fspq_pkg::KIND_PUSH:
                        begin
                            if (dp_status.full)
                                cmd.status = fspq_pkg::STATUS_DROPPED;
                            else
                            begin
                                cmd.push   = 1'b1;
                                cmd.status = fspq_pkg::STATUS_ACCEPTED;
                            end
                        end
                        fspq_pkg::KIND_POP:
                        begin
                            if (dp_status.empty)
                                cmd.status = fspq_pkg::STATUS_EMPTY;
                            else
                            begin
                                cmd.pop    = 1'b1;
                                cmd.serve  = 1'b1;
                                cmd.status = fspq_pkg::STATUS_SERVED;
                            end
                        end
                        fspq_pkg::KIND_POP_ALL:
                        begin
                            if (dp_status.empty)
                                cmd.status = fspq_pkg::STATUS_EMPTY;
                            else
                            begin
                                cmd.pop    = 1'b1;
                                cmd.serve  = 1'b1;
                                cmd.status = fspq_pkg::STATUS_SERVED;
                                cmd.last   = dp_status.one_left;
                                if (!dp_status.one_left)
                                    state_next = ST_DRAIN;
                            end
                        end
                        fspq_pkg::KIND_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            cmd.status = fspq_pkg::STATUS_CLEARED;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                cmd.emit   = 1'b1;
                cmd.pop    = 1'b1;
                cmd.serve  = 1'b1;
                cmd.status = fspq_pkg::STATUS_SERVED;
                cmd.last   = dp_status.one_left;
                if (dp_status.one_left)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A drain never runs on an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !dp_status.empty)
        else $error("fspq_ctrl: drain with empty queue");

    // The drain ends exactly after the final entry has been served.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && dp_status.one_left) |=> (state_reg == ST_IDLE))
        else $error("fspq_ctrl: drain did not end on last entry");

    // A push is never issued to a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !dp_status.full)
        else $error("fspq_ctrl: push issued while full");

endmodule

// File: hw/rtl/fspq_datapath.sv
// Datapath of the four-level stable priority queue: a sorted shift-register
// row of slots, the occupancy counter and the result registers. Uses fspq_pkg.
module fspq_datapath
#(
    parameter int CAPACITY = fspq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = fspq_pkg::ID_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  fspq_pkg::cmd_t                     cmd,
    input  logic [fspq_pkg::ENTRY_ID_W-1:0]    entry_id,
    input  logic [fspq_pkg::LEVEL_W-1:0]       level,
    output fspq_pkg::dp_status_t               dp_status,
    output logic                               done,
    output logic [fspq_pkg::ENTRY_ID_W-1:0]    served_id,
    output logic [fspq_pkg::CLASS_W-1:0]       table_class,
    output logic [fspq_pkg::STATUS_W-1:0]      status,
    output logic                               last
);

    localparam int ID_W  = (ID_BITS < fspq_pkg::ENTRY_ID_W) ? ID_BITS : fspq_pkg::ENTRY_ID_W;
    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [ID_W-1:0]                 slot_id_reg   [CAPACITY];
    logic [ID_W-1:0]                 slot_id_next  [CAPACITY];
    logic [fspq_pkg::CODE_W-1:0]     slot_lvl_reg  [CAPACITY];
    logic [fspq_pkg::CODE_W-1:0]     slot_lvl_next [CAPACITY];
    logic [OCC_W-1:0]                occ_reg;
    logic [OCC_W-1:0]                occ_next;
    logic [fspq_pkg::CODE_W-1:0]     push_code;
    logic [CAPACITY-1:0]             goes_after;

    logic                            done_reg;
    logic                            last_reg;
    logic [fspq_pkg::STATUS_W-1:0]   status_reg;
    logic [fspq_pkg::ENTRY_ID_W-1:0] served_id_reg;
    logic [fspq_pkg::CLASS_W-1:0]    class_reg;

    // Level 0 counts as 1 and anything above 4 as 4.
    always_comb
    begin
        if (level == '0)
            push_code = '0;
        else if (level >= fspq_pkg::LEVEL_W'(4))
            push_code = fspq_pkg::CODE_LEVEL4;
        else
            push_code = fspq_pkg::CODE_W'(level - fspq_pkg::LEVEL_W'(1));
    end

    // Slots are kept in service order, so these flags form a thermometer:
    // every slot from the insertion point onwards moves down by one.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            goes_after[i] = (OCC_W'(i) >= occ_reg) || (slot_lvl_reg[i] < push_code);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_slot
            always_comb
            begin
                slot_id_next[g]  = slot_id_reg[g];
                slot_lvl_next[g] = slot_lvl_reg[g];
                if (cmd.push)
                begin
                    if (g == 0)
                    begin
                        if (goes_after[g])
                        begin
                            slot_id_next[g]  = entry_id[ID_W-1:0];
                            slot_lvl_next[g] = push_code;
                        end
                    end
                    else if (goes_after[g])
                    begin
                        if (goes_after[(g == 0) ? 0 : g - 1])
                        begin
                            slot_id_next[g]  = slot_id_reg[(g == 0) ? 0 : g - 1];
                            slot_lvl_next[g] = slot_lvl_reg[(g == 0) ? 0 : g - 1];
                        end
                        else
                        begin
                            slot_id_next[g]  = entry_id[ID_W-1:0];
                            slot_lvl_next[g] = push_code;
                        end
                    end
                end
                else if (cmd.pop && (g < CAPACITY - 1))
                begin
                    slot_id_next[g]  = slot_id_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    slot_lvl_next[g] = slot_lvl_reg[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_id_reg[i]  <= slot_id_next[i];
            slot_lvl_reg[i] <= slot_lvl_next[i];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.clear)
            occ_next = '0;
        else if (cmd.push)
            occ_next = occ_reg + OCC_W'(1);
        else if (cmd.pop)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= cmd.status;
        last_reg   <= cmd.last;
        if (cmd.serve)
        begin
            served_id_reg <= fspq_pkg::ENTRY_ID_W'(slot_id_reg[0]);
            class_reg     <= fspq_pkg::class_of(slot_lvl_reg[0]);
        end
        else
        begin
            served_id_reg <= '0;
            class_reg     <= '0;
        end
    end

    assign dp_status.empty    = (occ_reg == '0);
    assign dp_status.one_left = (occ_reg == OCC_W'(1));
    assign dp_status.full     = (occ_reg >= OCC_W'(CAPACITY));

    assign done        = done_reg;
    assign served_id   = served_id_reg;
    assign table_class = class_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    // Occupancy never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("fspq_datapath: occupancy above capacity");

    // A pop is only issued while there is something to take.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (occ_reg != '0))
        else $error("fspq_datapath: pop from empty queue");

    // A served word always reports its entry's class, never an idle class.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.serve |=> (done && status == fspq_pkg::STATUS_SERVED
                       && table_class != 2'd3))
        else $error("fspq_datapath: served word malformed");

endmodule

// File: hw/rtl/four_level_stable_priority_queue_core.sv
// Top level of the four-level stable priority queue.
// Joins the controller (fspq_ctrl) and the datapath (fspq_datapath); uses fspq_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  request  | start in, busy out   | kind, entry_id, level
//  result   | done out (strobe)    | served_id, table_class, status, last
//
// A request word is taken on a rising edge with start high and busy low.
// Push, pop, and clear give one result word in the cycle after acceptance,
// and a new request can be taken in every cycle. Pop-all on an empty queue
// gives a single empty word; otherwise it gives one word per stored entry,
// one per cycle, starting in the cycle after acceptance, with one shift of
// the slot row per cycle; busy stays high until the cycle in which the final
// word (marked by last) is on the result ports. Reset (rst_n, asynchronous,
// active low) empties the queue at once. The receiver cannot stall: done is
// high for one cycle per result word.
//
// The queue is a row of slots kept in service order: highest level first and
// oldest first within a level. A push compares every occupied slot with the
// new level in parallel and shifts the tail down by one to open a gap; a pop
// shifts the whole row up by one. Slot contents beyond the occupancy are
// never read, so they need no reset.
module four_level_stable_priority_queue_core
#(
    parameter int CAPACITY = fspq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = fspq_pkg::ID_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         kind,
    input  logic [fspq_pkg::ENTRY_ID_W-1:0]    entry_id,
    input  logic [fspq_pkg::LEVEL_W-1:0]       level,
    output logic                               done,
    output logic [fspq_pkg::ENTRY_ID_W-1:0]    served_id,
    output logic [fspq_pkg::CLASS_W-1:0]       table_class,
    output logic [fspq_pkg::STATUS_W-1:0]      status,
    output logic                               last
);

    fspq_pkg::cmd_t       cmd;
    fspq_pkg::dp_status_t dp_status;

    // The controller issues at most one push or pop command per cycle.
    fspq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // The datapath registers every result word, so done and the payload
    // change together on the edge after the command.
    fspq_datapath
    #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .entry_id    (entry_id),
        .level       (level),
        .dp_status   (dp_status),
        .done        (done),
        .served_id   (served_id),
        .table_class (table_class),
        .status      (status),
        .last        (last)
    );

endmodule
